/* rtl/spa_pkg.sv */
// Package for the superpixel pixel assignment block: constants, payload and
// pipeline types. No dependencies.
package spa_pkg;

   // Image and cluster geometry
   localparam int IMAGE_WIDTH  = 512;
   localparam int IMAGE_HEIGHT = 512;
   localparam int MAX_CLUSTERS = 4096;
   localparam int STORE_DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);

   // Field widths
   localparam int ROW_W    = 9;
   localparam int CIDX_W   = 12;
   localparam int POS_W    = 13;
   localparam int LABEL_W  = 13;
   localparam int DIST_W   = 48;
   localparam int WEIGHT_W = 16;

   // Intermediate widths of the distance pipeline
   localparam int COLOUR_W  = 34;
   localparam int SPAT_W    = 27;
   localparam int PROD_W    = SPAT_W + WEIGHT_W;
   localparam int RAWDIST_W = PROD_W + 1;

   localparam logic [LABEL_W-1:0]  LABEL_NONE = LABEL_W'(4096);
   localparam logic [DIST_W-1:0]   DIST_MAX   = '1;
   localparam logic [WEIGHT_W-1:0] SPATIAL_WEIGHT_RESET = WEIGHT_W'(400);

   typedef struct packed {
      logic [8:0]         pixel_row;
      logic [8:0]         pixel_col;
      logic [14:0]        pixel_l;
      logic signed [15:0] pixel_a;
      logic signed [15:0] pixel_b;
      logic [11:0]        cluster_index;
      logic [14:0]        centre_l;
      logic signed [15:0] centre_a;
      logic signed [15:0] centre_b;
      logic [12:0]        centre_row;
      logic [12:0]        centre_col;
   } req_type;

   typedef struct packed {
      logic [12:0] label_now;
      logic [47:0] best_distance;
      logic        was_updated;
   } rsp_type;

   // One store entry
   typedef struct packed {
      logic [DIST_W-1:0]  distance;
      logic [LABEL_W-1:0] label;
   } entry_type;

   // Item handed from the distance pipeline to the store stage
   typedef struct packed {
      logic              valid;
      logic              in_image;
      logic              cidx_ok;
      logic [ADDR_W-1:0] addr;
      logic [CIDX_W-1:0] cidx;
      logic [DIST_W-1:0] distance;
   } item_type;

endpackage

/* rtl/spa_dist_pipe.sv */
// Five-stage distance pipeline: differences, squares, sums, spatial weighting,
// final add. Depends on spa_pkg.
module spa_dist_pipe (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  spa_pkg::req_type                  in_data,
   input  logic [spa_pkg::WEIGHT_W-1:0]      spatial_weight,
   output spa_pkg::item_type                 item
);

   // Common item tag carried along the stages
   typedef struct packed {
      logic                       in_image;
      logic                       cidx_ok;
      logic [spa_pkg::ADDR_W-1:0] addr;
      logic [spa_pkg::CIDX_W-1:0] cidx;
   } tag_type;

   logic [4:0] valid_ff;
   tag_type    tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   tag_type    tag_in;

   // stage 1: absolute differences
   logic signed [15:0] dl;
   logic signed [16:0] da, db;
   logic signed [13:0] dr, dc;
   logic [14:0] al1_ff;
   logic [15:0] aa1_ff, ab1_ff;
   logic [12:0] ar1_ff, ac1_ff;
   // stage 2: squares
   logic [29:0] sl2_ff;
   logic [31:0] sa2_ff, sb2_ff;
   logic [25:0] sr2_ff, sc2_ff;
   // stage 3: sums
   logic [spa_pkg::COLOUR_W-1:0] col3_ff;
   logic [spa_pkg::SPAT_W-1:0]   spat3_ff;
   // stage 4: weighted spatial part
   logic [spa_pkg::COLOUR_W-1:0] col4_ff;
   logic [spa_pkg::PROD_W-1:0]   prod4_ff;
   // stage 5: distance
   logic [spa_pkg::RAWDIST_W-1:0] dist5_ff;

   always_comb begin
      dl = signed'({1'b0, in_data.pixel_l}) - signed'({1'b0, in_data.centre_l});
      da = 17'(in_data.pixel_a) - 17'(in_data.centre_a);
      db = 17'(in_data.pixel_b) - 17'(in_data.centre_b);
      dr = signed'({1'b0, in_data.pixel_row, 4'b0000}) - signed'({1'b0, in_data.centre_row});
      dc = signed'({1'b0, in_data.pixel_col, 4'b0000}) - signed'({1'b0, in_data.centre_col});

      tag_in.in_image = (32'(in_data.pixel_row) < spa_pkg::IMAGE_HEIGHT) &&
                        (32'(in_data.pixel_col) < spa_pkg::IMAGE_WIDTH);
      tag_in.cidx_ok  = 32'(in_data.cluster_index) < spa_pkg::MAX_CLUSTERS;
      tag_in.addr     = spa_pkg::ADDR_W'(in_data.pixel_row) *
                        spa_pkg::ADDR_W'(spa_pkg::IMAGE_WIDTH) +
                        spa_pkg::ADDR_W'(in_data.pixel_col);
      tag_in.cidx     = in_data.cluster_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         al1_ff   <= dl[15] ? 15'(-dl) : dl[14:0];
         aa1_ff   <= da[16] ? 16'(-da) : da[15:0];
         ab1_ff   <= db[16] ? 16'(-db) : db[15:0];
         ar1_ff   <= dr[13] ? 13'(-dr) : dr[12:0];
         ac1_ff   <= dc[13] ? 13'(-dc) : dc[12:0];
         tag1_ff  <= tag_in;

         sl2_ff   <= al1_ff * al1_ff;
         sa2_ff   <= aa1_ff * aa1_ff;
         sb2_ff   <= ab1_ff * ab1_ff;
         sr2_ff   <= ar1_ff * ar1_ff;
         sc2_ff   <= ac1_ff * ac1_ff;
         tag2_ff  <= tag1_ff;

         col3_ff  <= spa_pkg::COLOUR_W'(sl2_ff) + spa_pkg::COLOUR_W'(sa2_ff) +
                     spa_pkg::COLOUR_W'(sb2_ff);
         spat3_ff <= spa_pkg::SPAT_W'(sr2_ff) + spa_pkg::SPAT_W'(sc2_ff);
         tag3_ff  <= tag2_ff;

         prod4_ff <= spa_pkg::PROD_W'(spat3_ff) * spa_pkg::PROD_W'(spatial_weight);
         col4_ff  <= col3_ff;
         tag4_ff  <= tag3_ff;

         // sum stays below 2^44, so no saturation is needed at 48 bits
         dist5_ff <= spa_pkg::RAWDIST_W'(col4_ff) + spa_pkg::RAWDIST_W'(prod4_ff);
         tag5_ff  <= tag4_ff;
      end
   end

   assign item.valid    = valid_ff[4];
   assign item.in_image = tag5_ff.in_image;
   assign item.cidx_ok  = tag5_ff.cidx_ok;
   assign item.addr     = tag5_ff.addr;
   assign item.cidx     = tag5_ff.cidx;
   assign item.distance = spa_pkg::DIST_W'(dist5_ff);

endmodule

/* rtl/spa_store.sv */
// Per-pixel best distance / label store with read-modify-write, forwarding
// and the post-reset clearing sweep. Depends on spa_pkg.
module spa_store (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  spa_pkg::item_type  item_in,
   output logic               busy,
   output logic               res_valid,
   output spa_pkg::rsp_type   res_data
);

   spa_pkg::entry_type mem [spa_pkg::STORE_DEPTH];

   logic                       clr_busy_ff;
   logic [spa_pkg::ADDR_W-1:0] clr_addr_ff;

   spa_pkg::item_type  cmp_ff;
   spa_pkg::entry_type rd_data_ff;
   logic               fwd_hit_ff;
   spa_pkg::entry_type fwd_data_ff;

   spa_pkg::entry_type old_entry, new_entry, wr_data, clr_entry;
   logic               upd, wr_en, fwd_hit_in;
   logic [spa_pkg::ADDR_W-1:0] wr_addr;

   always_comb begin
      clr_entry.distance = spa_pkg::DIST_MAX;
      clr_entry.label    = spa_pkg::LABEL_NONE;

      old_entry = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      upd = cmp_ff.valid && cmp_ff.in_image && cmp_ff.cidx_ok &&
            (cmp_ff.distance < old_entry.distance);
      new_entry.distance = upd ? cmp_ff.distance : old_entry.distance;
      new_entry.label    = upd ? spa_pkg::LABEL_W'(cmp_ff.cidx) : old_entry.label;

      wr_en   = clr_busy_ff || (adv && upd);
      wr_addr = clr_busy_ff ? clr_addr_ff : cmp_ff.addr;
      wr_data = clr_busy_ff ? clr_entry : new_entry;

      // item entering now reads the same entry this one is writing
      fwd_hit_in = cmp_ff.valid && cmp_ff.in_image && item_in.valid &&
                   item_in.in_image && (item_in.addr == cmp_ff.addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == spa_pkg::ADDR_W'(spa_pkg::STORE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (adv) begin
         rd_data_ff <= mem[item_in.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff.valid <= 1'b0;
      end else if (adv) begin
         cmp_ff.valid <= item_in.valid;
      end
      if (adv) begin
         cmp_ff.in_image <= item_in.in_image;
         cmp_ff.cidx_ok  <= item_in.cidx_ok;
         cmp_ff.addr     <= item_in.addr;
         cmp_ff.cidx     <= item_in.cidx;
         cmp_ff.distance <= item_in.distance;
         fwd_hit_ff      <= fwd_hit_in;
         fwd_data_ff     <= new_entry;
      end
   end

   assign busy      = clr_busy_ff;
   assign res_valid = cmp_ff.valid;

   always_comb begin
      if (cmp_ff.in_image) begin
         res_data.label_now     = new_entry.label;
         res_data.best_distance = new_entry.distance;
      end else begin
         res_data.label_now     = spa_pkg::LABEL_NONE;
         res_data.best_distance = spa_pkg::DIST_MAX;
      end
      res_data.was_updated = upd;
   end

endmodule

/* rtl/superpixel_pixel_assignment.sv */
// Top level of the superpixel pixel assignment step: configuration register,
// stall control and result register. Depends on spa_pkg, spa_dist_pipe, spa_store.
//
// Each request transaction carries one pixel (row, column, Lab colour) and one
// cluster centre (index, Lab colour, Q9.4 position). The block forms
// D = dL^2 + da^2 + db^2 + spatial_weight * (drow^2 + dcol^2) with 16 fraction
// bits, compares it with the pixel's best distance in an on-chip store
// (one entry per pixel, addressed row * IMAGE_WIDTH + col) and keeps the
// smaller, taking the cluster as the pixel's label on a strict improvement.
// Each request yields one response transaction: the pixel's label and best
// distance after the step and a was_updated flag. Throughput is one
// transaction per clock unless rsp_stall or the store sweep holds the flow;
// a request passes five distance stages, the store compare stage and the
// response register. The store is a single-port-write, single-port-read RAM; a
// back-to-back item on the same pixel takes its value from a forwarding
// register. After reset the store is swept to "no label, maximum distance",
// one entry per clock, for all STORE_DEPTH (262144) entries; req_stall stays high
// until the sweep ends, while csr writes are taken at any time.
// spatial_weight (reset 400) must only be written while the block is idle.
module superpixel_pixel_assignment (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  spa_pkg::req_type              req_data,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output spa_pkg::rsp_type              rsp_data,
   // spatial_weight register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spa_pkg::WEIGHT_W-1:0]  csr_data
);

   logic [spa_pkg::WEIGHT_W-1:0] spatial_weight_ff;

   logic              adv;        // whole pipeline steps when high
   logic              req_take;   // request transaction accepted
   logic              clr_busy;
   spa_pkg::item_type dist_item;
   logic              res_valid;
   spa_pkg::rsp_type  res_data;

   logic              rsp_valid_ff;
   spa_pkg::rsp_type  rsp_data_ff;

   // Pipeline moves unless a finished response sits stalled in the output reg.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || clr_busy;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spatial_weight_ff <= spa_pkg::SPATIAL_WEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         spatial_weight_ff <= csr_data;
      end
   end

   // distance math: five register stages
   spa_dist_pipe u_dist (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (req_take),
      .in_data        (req_data),
      .spatial_weight (spatial_weight_ff),
      .item           (dist_item)
   );

   // store read, compare, write-back
   spa_store u_store (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .item_in   (dist_item),
      .busy      (clr_busy),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/label_tracker_pkg.sv */
// Per-pixel label and distance tracker for the superpixel assignment testbench.
// Depends on spa_pkg for payload types, geometry and reset constants.
`timescale 1ns / 1ps

package label_tracker_pkg;
   import spa_pkg::*;

   class label_tracker;
      logic [WEIGHT_W-1:0] spatial_weight;
      bit [DIST_W-1:0]     dist_store [STORE_DEPTH];
      bit [LABEL_W-1:0]    label_store [STORE_DEPTH];
      rsp_type             pending_labels [$];
      int unsigned         mismatches;

      function new();
         for (int i = 0; i < STORE_DEPTH; i++) begin
            dist_store[i]  = DIST_MAX;
            label_store[i] = LABEL_NONE;
         end
         spatial_weight = SPATIAL_WEIGHT_RESET;
         mismatches     = 0;
      endfunction

      function void set_weight(logic [WEIGHT_W-1:0] w);
         spatial_weight = w;
      endfunction

      function int pending();
         return pending_labels.size();
      endfunction

      // Accepted request transaction: step the pixel's store entry, queue the outcome.
      function void take_pixel(req_type r);
         longint  dl, da, db, dr, dc, total;
         int      addr;
         rsp_type outcome;
         outcome.was_updated = 1'b0;
         if (int'(r.pixel_row) >= IMAGE_HEIGHT || int'(r.pixel_col) >= IMAGE_WIDTH) begin
            outcome.label_now     = LABEL_NONE;
            outcome.best_distance = DIST_MAX;
            pending_labels.push_back(outcome);
            return;
         end
         dl = longint'(r.pixel_l) - longint'(r.centre_l);
         da = longint'($signed(r.pixel_a)) - longint'($signed(r.centre_a));
         db = longint'($signed(r.pixel_b)) - longint'($signed(r.centre_b));
         // positions compared in Q.4
         dr = longint'({r.pixel_row, 4'b0000}) - longint'(r.centre_row);
         dc = longint'({r.pixel_col, 4'b0000}) - longint'(r.centre_col);
         total = dl * dl + da * da + db * db
                 + (dr * dr + dc * dc) * longint'(spatial_weight);
         if (total > longint'(DIST_MAX))
            total = longint'(DIST_MAX);
         addr = int'(r.pixel_row) * IMAGE_WIDTH + int'(r.pixel_col);
         // strict improvement only; ties keep the earlier cluster
         if (int'(r.cluster_index) < MAX_CLUSTERS && total < longint'(dist_store[addr])) begin
            dist_store[addr]    = total[DIST_W-1:0];
            label_store[addr]   = {1'b0, r.cluster_index};
            outcome.was_updated = 1'b1;
         end
         outcome.label_now     = label_store[addr];
         outcome.best_distance = dist_store[addr];
         pending_labels.push_back(outcome);
      endfunction

      // Accepted response transaction: compare with the oldest queued outcome.
      function void match_result(rsp_type got);
         rsp_type want;
         if (pending_labels.size() == 0) begin
            $display("%0t: unexpected result label %0d distance %0h updated %0b",
                     $time, got.label_now, got.best_distance, got.was_updated);
            mismatches++;
            return;
         end
         want = pending_labels.pop_front();
         if (got.label_now !== want.label_now) begin
            $display("%0t: label_now expected %0d got %0d",
                     $time, want.label_now, got.label_now);
            mismatches++;
         end
         if (got.best_distance !== want.best_distance) begin
            $display("%0t: best_distance expected %0h got %0h",
                     $time, want.best_distance, got.best_distance);
            mismatches++;
         end
         if (got.was_updated !== want.was_updated) begin
            $display("%0t: was_updated expected %0b got %0b",
                     $time, want.was_updated, got.was_updated);
            mismatches++;
         end
      endfunction
   endclass

endpackage

/* tb/superpixel_pixel_assignment_tb.sv */
// Testbench top for superpixel_pixel_assignment: drives pixel/cluster requests,
// writes spatial_weight, checks every response. Depends on spa_pkg, label_tracker_pkg.
`timescale 1ns / 1ps

module superpixel_pixel_assignment_tb;
   import spa_pkg::*;
   import label_tracker_pkg::*;

   localparam int PIPE_LATENCY = 7;            // accept to response valid
   localparam int REQ_BITS     = $bits(req_type);
   localparam int HOT_PIXELS   = 16;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [WEIGHT_W-1:0] csr_data;

   label_tracker tracker;

   // Request feed: main flow pushes, the driver below pops at the handshake.
   req_type     pixel_queue [$];
   int unsigned pushed_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // Small pool of pixels hit over and over, so the store read-modify-write
   // path and the forwarding register see plenty of repeat traffic.
   logic [8:0] hot_row [HOT_PIXELS];
   logic [8:0] hot_col [HOT_PIXELS];
   req_type    last_req = '0;

   superpixel_pixel_assignment dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop. The timeout leaves ample margin over the post-reset store sweep
   // and the rest of the run.
   initial begin
      #(10_000_000);
      $display("Regression FAIL");
      $finish;
   end

   // Request driver. Outputs are sampled at the edge (pre-update values), so a
   // transaction counts when valid was high and stall low going into the edge.
   // Valid and data only move when the channel is free; a stalled transaction
   // holds. One nonblocking update per signal per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            tracker.take_pixel(req_data);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pixel_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side back-pressure, redrawn every clock.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_result(rsp_data);
   end

   function automatic req_type make_pixel(int row, int col, int l, int a, int b, int cidx,
                                          int cl, int ca, int cb, int crow, int ccol);
      req_type r;
      r.pixel_row     = 9'(row);
      r.pixel_col     = 9'(col);
      r.pixel_l       = 15'(l);
      r.pixel_a       = 16'(a);
      r.pixel_b       = 16'(b);
      r.cluster_index = 12'(cidx);
      r.centre_l      = 15'(cl);
      r.centre_a      = 16'(ca);
      r.centre_b      = 16'(cb);
      r.centre_row    = 13'(crow);
      r.centre_col    = 13'(ccol);
      return r;
   endfunction

   // Random request: mostly pool pixels or a repeat of the last one, the rest
   // anywhere in the image. Half the centers sit close to the pixel in color
   // and position so distances are small and labels keep changing.
   function automatic req_type random_pixel();
      req_type     r;
      int unsigned pick;
      int unsigned slot;
      r    = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         slot        = $urandom_range(0, HOT_PIXELS - 1);
         r.pixel_row = hot_row[slot];
         r.pixel_col = hot_col[slot];
      end else if (pick < 75) begin
         r.pixel_row = last_req.pixel_row;
         r.pixel_col = last_req.pixel_col;
      end
      if ($urandom_range(0, 1) == 1) begin
         r.centre_l   = r.pixel_l + 15'($urandom_range(0, 63) - 32);
         r.centre_a   = r.pixel_a + 16'($urandom_range(0, 63) - 32);
         r.centre_b   = r.pixel_b + 16'($urandom_range(0, 63) - 32);
         r.centre_row = {r.pixel_row, 4'b0000} + 13'($urandom_range(0, 255) - 128);
         r.centre_col = {r.pixel_col, 4'b0000} + 13'($urandom_range(0, 255) - 128);
      end
      // now and then pin lightness to its legal top
      if ($urandom_range(0, 19) == 0)
         r.pixel_l = 15'd25600;
      last_req = r;
      return r;
   endfunction

   task automatic push_pixel(req_type r);
      pixel_queue.push_back(r);
      pushed_count++;
   endtask

   // Wait until every pushed request is taken and answered, then let the
   // pipeline run dry.
   task automatic settle_block();
      do @(posedge clock);
      while (accepted_count != pushed_count || tracker.pending() != 0);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_weight(logic [WEIGHT_W-1:0] w);
      csr_valid <= 1'b1;
      csr_data  <= w;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_weight(w);
   endtask

   // pause_at >= 0: hold the sender there until everything outstanding is back.
   task automatic run_random(int count, int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at)
            settle_block();
         push_pixel(random_pixel());
      end
   endtask

   initial begin
      reset     <= 1'b1;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      tracker = new();
      for (int i = 0; i < HOT_PIXELS; i++) begin
         hot_row[i] = 9'($urandom);
         hot_col[i] = 9'($urandom);
      end
      // two opposite image corners belong to the pool
      hot_row[0] = 9'd0;
      hot_col[0] = 9'd0;
      hot_row[1] = 9'd511;
      hot_col[1] = 9'd511;

      send_idle_pct  = 16;
      recv_stall_pct = 57;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset weight of 400. The sender just waits out the store
      // sweep behind req_stall.
      // Exact match at the origin: zero distance, first label taken.
      push_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Same pixel right behind, same distance from another cluster: tie keeps label.
      push_pixel(make_pixel(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      // Far corner, color components at opposite extremes, center at origin.
      push_pixel(make_pixel(511, 511, 32767, -32768, -32768, 4095,
                            0, 32767, 32767, 0, 0));
      // Closer center takes over.
      push_pixel(make_pixel(511, 511, 32767, -32768, -32768, 7,
                            25600, -32700, -32768, 8176, 8176));
      // Same distance from a later cluster: no update.
      push_pixel(make_pixel(511, 511, 32767, -32768, -32768, 8,
                            25600, -32700, -32768, 8176, 8176));
      // Center position at its maximum code.
      push_pixel(make_pixel(0, 511, 25600, 32767, -32768, 100,
                            25600, 32767, -32768, 8191, 8191));
      push_pixel(make_pixel(511, 0, 12800, 32767, -32768, 200,
                            0, -32768, 32767, 0, 8191));
      // Moderate first hit, then a worse cluster loses, then an exact one wins.
      push_pixel(make_pixel(3, 5, 1000, 100, -100, 2, 1010, 90, -90, 50, 84));
      push_pixel(make_pixel(3, 5, 1000, 100, -100, 3, 20000, -5000, 5000, 4000, 10));
      push_pixel(make_pixel(3, 5, 1000, 100, -100, 4, 1000, 100, -100, 48, 80));
      // Neighbor pixels interleaved: forwarding must follow the address.
      push_pixel(make_pixel(3, 6, 500, 0, 0, 10, 600, 0, 0, 48, 96));
      push_pixel(make_pixel(3, 5, 1000, 100, -100, 11, 1000, 100, -100, 48, 80));
      push_pixel(make_pixel(3, 6, 500, 0, 0, 12, 550, 0, 0, 48, 96));
      push_pixel(make_pixel(3, 6, 500, 0, 0, 13, 500, 0, 0, 48, 96));
      settle_block();

      // Random phases across the weight range: no spatial term, full weight,
      // then an arbitrary one.
      write_weight(16'h0000);
      run_random(450, 225);
      settle_block();

      send_idle_pct  = 57;
      recv_stall_pct = 16;
      write_weight(16'hFFFF);
      run_random(450, -1);
      settle_block();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_weight(WEIGHT_W'($urandom_range(1, 65534)));
      run_random(450, -1);
      settle_block();

      if (tracker.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
